/* rtl/brdt_pkg.sv */
//------------------------------------------------------------------------------
// brdt_pkg
// Shared types and codes of the block request dependency tracker.
//------------------------------------------------------------------------------
`default_nettype none
package brdt_pkg;

    localparam int OFS_W = 63;
    localparam int LEN_W = 32;
    localparam int TAG_W = 16;
    localparam int KIND_W = 2;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 6;

    localparam logic [1:0] REQ_SUBMIT   = 2'd0;
    localparam logic [1:0] REQ_ISSUE    = 2'd1;
    localparam logic [1:0] REQ_COMPLETE = 2'd2;
    localparam logic [1:0] REQ_CANCEL   = 2'd3;

    localparam logic [1:0] KIND_FLUSH = 2'd2;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [2:0] STAT_INFLIGHT  = 3'd3;
    localparam logic [2:0] STAT_NONE      = 3'd4;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_BLOCKED  = 2'd1;
    localparam logic [1:0] ST_READY    = 2'd2;
    localparam logic [1:0] ST_INFLIGHT = 2'd3;

    localparam logic [OFS_W-1:0] MAX_OFFSET = {OFS_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } brdt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
    } brdt_stat_t;

endpackage
`default_nettype wire

/* rtl/block_request_dependency_tracker_unit.sv */
//------------------------------------------------------------------------------
// block_request_dependency_tracker_unit
// Tracks disk requests in a slot pool with free, waiting and in-flight order.
//------------------------------------------------------------------------------
// Channel | Dir | Contents
// s_axis  | in  | one request: type, tag, kind, start, length, done slot
// m_axis  | out | one result per request: status, slot, tag, kind, ready
//
// Each request is first captured (the end offset is formed here); then the
// per-slot compares and the oldest-entry selections run and the slot state
// is updated; then the result is presented and held until it is taken.
// A new request is taken only once the result has been transferred.
// Reset marks all slots free, in descending order; no clearing pass is needed.
//------------------------------------------------------------------------------
`default_nettype none
module block_request_dependency_tracker_unit
#(
    parameter int SLOTS = 64
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // req_type[1:0], req_tag[17:2], access_kind[19:18], start_offset[82:20],
    // byte_length[114:83], done_slot[120:115]
    input  wire logic [127:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[2:0], slot_number[8:3], issued_tag[24:9], issued_kind[26:25],
    // ready_now[27]
    output logic [31:0]       m_axis_tdata
);

    brdt_pkg::brdt_cmd_t  cmd;
    brdt_pkg::brdt_stat_t stat;

    logic [2:0]  status;
    logic [5:0]  slot_number;
    logic [15:0] issued_tag;
    logic [1:0]  issued_kind;
    logic        ready_now;

    brdt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    brdt_dp #(.SLOTS(SLOTS)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (s_axis_tdata[1:0]),
        .req_tag      (s_axis_tdata[17:2]),
        .access_kind  (s_axis_tdata[19:18]),
        .start_offset (s_axis_tdata[82:20]),
        .byte_length  (s_axis_tdata[114:83]),
        .done_slot    (s_axis_tdata[120:115]),
        .status       (status),
        .slot_number  (slot_number),
        .issued_tag   (issued_tag),
        .issued_kind  (issued_kind),
        .ready_now    (ready_now)
    );

    // The upper output bits are zero padding.
    assign m_axis_tdata = {4'd0, ready_now, issued_kind, issued_tag, slot_number, status};

endmodule
`default_nettype wire

/* rtl/brdt_ctrl.sv */
//------------------------------------------------------------------------------
// brdt_ctrl
// Controller: accepts a request, runs the capture and execute steps, holds result.
//------------------------------------------------------------------------------
`default_nettype none
module brdt_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output brdt_pkg::brdt_cmd_t     cmd,
    input  wire brdt_pkg::brdt_stat_t stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                if (stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/brdt_dp.sv */
//------------------------------------------------------------------------------
// brdt_dp
// Datapath: per-slot entries, list order by an age matrix, compares.
//------------------------------------------------------------------------------
`default_nettype none
module brdt_dp
#(
    parameter int SLOTS = 64
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire brdt_pkg::brdt_cmd_t             cmd,
    output brdt_pkg::brdt_stat_t                 stat,
    input  wire logic [1:0]                      req_type,
    input  wire logic [brdt_pkg::TAG_W-1:0]      req_tag,
    input  wire logic [brdt_pkg::KIND_W-1:0]     access_kind,
    input  wire logic [brdt_pkg::OFS_W-1:0]      start_offset,
    input  wire logic [brdt_pkg::LEN_W-1:0]      byte_length,
    input  wire logic [brdt_pkg::SLOT_W-1:0]     done_slot,
    output logic [brdt_pkg::STAT_W-1:0]          status,
    output logic [brdt_pkg::SLOT_W-1:0]          slot_number,
    output logic [brdt_pkg::TAG_W-1:0]           issued_tag,
    output logic [brdt_pkg::KIND_W-1:0]          issued_kind,
    output logic                                 ready_now
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW = SW + 1;

    // Per-slot stores.
    logic [brdt_pkg::OFS_W-1:0]  start_reg [SLOTS];
    logic [brdt_pkg::OFS_W-1:0]  end_reg   [SLOTS];
    logic [brdt_pkg::TAG_W-1:0]  tag_reg   [SLOTS];
    logic [brdt_pkg::KIND_W-1:0] kind_reg  [SLOTS];
    logic [1:0]                  st_reg    [SLOTS];

    // Age matrix: bit j of row i is set when slot j entered its current list
    // before slot i entered its own. Every list only appends at its tail, so
    // within one list this is exactly list order.
    logic [SLOTS-1:0]            older_reg [SLOTS];

    // Captured request.
    logic [1:0]                  typ_reg;
    logic [brdt_pkg::TAG_W-1:0]  rtag_reg;
    logic [brdt_pkg::KIND_W-1:0] rkind_reg;
    logic [brdt_pkg::OFS_W-1:0]  rstart_reg;
    logic [brdt_pkg::OFS_W-1:0]  rend_reg;
    logic [brdt_pkg::SLOT_W-1:0] rdone_reg;

    logic [brdt_pkg::OFS_W:0] sum;
    assign sum = {1'b0, start_offset} + {{(brdt_pkg::OFS_W+1-brdt_pkg::LEN_W){1'b0}}, byte_length};

    // Per-slot match vectors.
    logic [SLOTS-1:0] free_v, blk_v, rdy_v, wtag_v, itag_v;
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            free_v[i] = (st_reg[i] == brdt_pkg::ST_FREE);
            blk_v[i]  = (st_reg[i] != brdt_pkg::ST_FREE) && (end_reg[i] == rstart_reg);
            rdy_v[i]  = (st_reg[i] == brdt_pkg::ST_READY);
            wtag_v[i] = (st_reg[i] == brdt_pkg::ST_READY || st_reg[i] == brdt_pkg::ST_BLOCKED)
                        && (tag_reg[i] == rtag_reg);
            itag_v[i] = (st_reg[i] == brdt_pkg::ST_INFLIGHT) && (tag_reg[i] == rtag_reg);
        end
    end

    // Oldest-of selection: a candidate wins when no other candidate is older.
    // All candidates sit on one list, so exactly one wins and the OR encodes it.
    function automatic logic [SW:0] oldest(input logic [SLOTS-1:0] v,
                                           input logic [SLOTS-1:0] ot [SLOTS]);
        logic [SW:0] r;
        r = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (v[i] && !(|(v & ot[i])))
            begin
                r = r | {1'b1, SW'(i)};
            end
        end
        return r;
    endfunction

    logic [SW:0] f_sel, r_sel, w_sel, i_sel;
    assign f_sel = oldest(free_v, older_reg);
    assign r_sel = oldest(rdy_v, older_reg);
    assign w_sel = oldest(wtag_v, older_reg);
    assign i_sel = oldest(itag_v, older_reg);

    logic            rel_en;
    logic [SW-1:0]   rel_slot;
    logic [brdt_pkg::OFS_W-1:0] rel_end;
    always_comb
    begin
        rel_en   = 1'b0;
        rel_slot = '0;
        if (typ_reg == brdt_pkg::REQ_COMPLETE)
        begin
            rel_slot = SW'(rdone_reg);
            rel_en   = (QW'(rdone_reg) < QW'(SLOTS)) && !free_v[SW'(rdone_reg)];
        end
        else if (typ_reg == brdt_pkg::REQ_CANCEL)
        begin
            rel_slot = w_sel[SW-1:0];
            rel_en   = w_sel[SW];
        end
        rel_end = end_reg[rel_slot];
    end

    // The one slot that enters the tail of a list in this operation.
    logic            ent_en;
    logic [SW-1:0]   ent_slot;
    always_comb
    begin
        ent_en   = 1'b0;
        ent_slot = '0;
        unique case (typ_reg)
            brdt_pkg::REQ_SUBMIT:
            begin
                ent_en   = f_sel[SW];
                ent_slot = f_sel[SW-1:0];
            end
            brdt_pkg::REQ_ISSUE:
            begin
                ent_en   = r_sel[SW];
                ent_slot = r_sel[SW-1:0];
            end
            default:
            begin
                ent_en   = rel_en;
                ent_slot = rel_slot;
            end
        endcase
    end

    assign stat.done = cmd.execute;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // The free list starts in descending order: the highest slot is
            // the oldest.
            for (int i = 0; i < SLOTS; i++)
            begin
                st_reg[i] <= brdt_pkg::ST_FREE;
                for (int j = 0; j < SLOTS; j++)
                begin
                    older_reg[i][j] <= (j > i);
                end
            end
        end
        else if (cmd.execute)
        begin
            unique case (typ_reg)
                brdt_pkg::REQ_SUBMIT:
                begin
                    if (f_sel[SW])
                    begin
                        st_reg[f_sel[SW-1:0]] <= (|blk_v) ? brdt_pkg::ST_BLOCKED
                                                           : brdt_pkg::ST_READY;
                    end
                end
                brdt_pkg::REQ_ISSUE:
                begin
                    if (r_sel[SW])
                    begin
                        st_reg[r_sel[SW-1:0]] <= brdt_pkg::ST_INFLIGHT;
                    end
                end
                default:
                begin
                    if (rel_en)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (SW'(i) != rel_slot && st_reg[i] == brdt_pkg::ST_BLOCKED
                                && start_reg[i] == rel_end)
                            begin
                                st_reg[i] <= brdt_pkg::ST_READY;
                            end
                        end
                        st_reg[rel_slot] <= brdt_pkg::ST_FREE;
                    end
                end
            endcase
            if (ent_en)
            begin
                // The entering slot becomes the newest of all.
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (SW'(i) != ent_slot)
                    begin
                        older_reg[i][ent_slot] <= 1'b0;
                    end
                end
                older_reg[ent_slot] <= ~({{(SLOTS-1){1'b0}}, 1'b1} << ent_slot);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            typ_reg    <= req_type;
            rtag_reg   <= req_tag;
            rkind_reg  <= access_kind;
            rstart_reg <= start_offset;
            rdone_reg  <= done_slot;
            if (access_kind == brdt_pkg::KIND_FLUSH || sum[brdt_pkg::OFS_W])
                rend_reg <= brdt_pkg::MAX_OFFSET;
            else
                rend_reg <= sum[brdt_pkg::OFS_W-1:0];
        end
        if (cmd.execute)
        begin
            status      <= brdt_pkg::STAT_OK;
            slot_number <= '0;
            issued_tag  <= '0;
            issued_kind <= '0;
            ready_now   <= 1'b0;
            unique case (typ_reg)
                brdt_pkg::REQ_SUBMIT:
                begin
                    if (!f_sel[SW])
                        status <= brdt_pkg::STAT_FULL;
                    else
                    begin
                        start_reg[f_sel[SW-1:0]] <= rstart_reg;
                        end_reg[f_sel[SW-1:0]]   <= rend_reg;
                        tag_reg[f_sel[SW-1:0]]   <= rtag_reg;
                        kind_reg[f_sel[SW-1:0]]  <= rkind_reg;
                        slot_number <= brdt_pkg::SLOT_W'(f_sel[SW-1:0]);
                        ready_now   <= !(|blk_v);
                    end
                end
                brdt_pkg::REQ_ISSUE:
                begin
                    if (!r_sel[SW])
                        status <= brdt_pkg::STAT_NONE;
                    else
                    begin
                        slot_number <= brdt_pkg::SLOT_W'(r_sel[SW-1:0]);
                        issued_tag  <= tag_reg[r_sel[SW-1:0]];
                        issued_kind <= kind_reg[r_sel[SW-1:0]];
                    end
                end
                brdt_pkg::REQ_COMPLETE:
                begin
                    if (!rel_en)
                        status <= brdt_pkg::STAT_NOT_FOUND;
                    else
                        slot_number <= rdone_reg;
                end
                brdt_pkg::REQ_CANCEL:
                begin
                    if (w_sel[SW])
                        slot_number <= brdt_pkg::SLOT_W'(w_sel[SW-1:0]);
                    else if (i_sel[SW])
                    begin
                        status      <= brdt_pkg::STAT_INFLIGHT;
                        slot_number <= brdt_pkg::SLOT_W'(i_sel[SW-1:0]);
                    end
                    else
                        status <= brdt_pkg::STAT_NOT_FOUND;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
